>>> src/rgb_to_hsv_hsl_converter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB to HSV/HSL converter
// Clocked implication helpers used by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_HSL_CONVERTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhc check failed");

// Consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhc check failed");

`endif

>>> src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types, constants and the divider step shared by the converter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int RHC_Q_BITS          = 16;
    localparam int RHC_STEPS_PER_STAGE = 2;
    localparam int RHC_DIV_STAGES      = RHC_Q_BITS / RHC_STEPS_PER_STAGE;

    localparam logic [15:0] RHC_SAT_MAX  = 16'hFFFF;
    localparam logic [8:0]  RHC_HALF_SUM = 9'd255;
    localparam logic [8:0]  RHC_FULL_SUM = 9'd510;

    // Word carried through the divider pipeline: two restoring divisions in
    // flight (hue and saturation) plus the fields that ride along.
    typedef struct packed {
        logic [10:0] hue_rem;
        logic [10:0] hue_den;
        logic [15:0] hue_q;
        logic [7:0]  sat_rem;
        logic [7:0]  sat_den;
        logic [15:0] sat_q;
        logic [8:0]  level;
        logic [7:0]  alpha;
        logic        hue_zero;
        logic        sat_zero;
        logic        sat_full;
    } rhc_div_t;

    // Advance both divisions by RHC_STEPS_PER_STAGE quotient bits.
    // Remainders stay below their divisors, so the shifted value fits one
    // extra bit.
    function automatic rhc_div_t rhc_div_stage(input rhc_div_t w);
        rhc_div_t    r;
        logic [11:0] ht;
        logic [8:0]  st;
        logic        hb;
        logic        sb;
        r = w;
        for (int k = 0; k < RHC_STEPS_PER_STAGE; k++)
        begin
            ht = {r.hue_rem, 1'b0};
            hb = (ht >= {1'b0, r.hue_den});
            if (hb)
            begin
                ht = ht - {1'b0, r.hue_den};
            end
            r.hue_rem = ht[10:0];
            r.hue_q   = {r.hue_q[14:0], hb};

            st = {r.sat_rem, 1'b0};
            sb = (st >= {1'b0, r.sat_den});
            if (sb)
            begin
                st = st - {1'b0, r.sat_den};
            end
            r.sat_rem = st[7:0];
            r.sat_q   = {r.sat_q[14:0], sb};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/rhc_cfg_if.sv
// ----------------------------------------------------------------------------
// rhc_cfg_if
// Configuration write channel: one word carries the mode bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_cfg_if;
    logic valid;
    logic ready;
    logic hsl_mode;

    modport source (output valid, output hsl_mode, input ready);
    modport sink   (input valid, input hsl_mode, output ready);
endinterface

`default_nettype wire

>>> src/rhc_pixel_in_if.sv
// ----------------------------------------------------------------------------
// rhc_pixel_in_if
// Input pixel channel: one RGBA word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_pixel_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_in;

    modport source (output valid, output red, output green, output blue,
                    output alpha_in, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha_in, output ready);
endinterface

`default_nettype wire

>>> src/rhc_pixel_out_if.sv
// ----------------------------------------------------------------------------
// rhc_pixel_out_if
// Output channel: hue, saturation, level and alpha, one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_pixel_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [8:0]  level;
    logic [7:0]  alpha_out;

    modport source (output valid, output hue, output saturation, output level,
                    output alpha_out, input ready);
    modport sink   (input valid, input hue, input saturation, input level,
                    input alpha_out, output ready);
endinterface

`default_nettype wire

>>> src/rhc_div_pipe.sv
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Pipelined restoring divider pair: hue and saturation quotients, a fixed
// number of quotient bits per stage, with a per-stage valid/ready chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_pipe (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rhc_pkg::rhc_div_t in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rhc_pkg::rhc_div_t     out_word
);
    import rhc_pkg::*;

    logic [RHC_DIV_STAGES-1:0] valid_reg;
    logic [RHC_DIV_STAGES-1:0] valid_next;
    logic [RHC_DIV_STAGES-1:0] stage_ready;
    logic [RHC_DIV_STAGES-1:0] prev_valid;
    rhc_div_t                  word_reg  [RHC_DIV_STAGES];
    rhc_div_t                  word_next [RHC_DIV_STAGES];

    // A stage takes a word when it is empty or its word moves on.
    always_comb
    begin
        stage_ready[RHC_DIV_STAGES-1] = !valid_reg[RHC_DIV_STAGES-1] || out_ready;
        for (int i = RHC_DIV_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb
    begin
        prev_valid[0] = in_valid;
        word_next[0]  = rhc_div_stage(in_word);
        for (int i = 1; i < RHC_DIV_STAGES; i++)
        begin
            prev_valid[i] = valid_reg[i-1];
            word_next[i]  = rhc_div_stage(word_reg[i-1]);
        end
        for (int i = 0; i < RHC_DIV_STAGES; i++)
        begin
            valid_next[i] = stage_ready[i] ? prev_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RHC_DIV_STAGES; i++)
        begin
            if (stage_ready[i] && prev_valid[i])
            begin
                word_reg[i] <= word_next[i];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[RHC_DIV_STAGES-1];
    assign out_word  = word_reg[RHC_DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/rgb_to_hsv_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_converter
// RGBA pixel to hue / saturation / level, HSV or HSL selected by a mode bit.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock when the output is not stalled
// and returns one result word per pixel, in order: one stage finds max
// and min, one forms the hue numerator and the saturation divisor, eight
// divider stages produce two quotient bits each for both 16-bit
// quotients, and a final output register applies the zero and
// full-scale cases. Each stage has its own valid bit and moves on when
// the stage after it has room, so input is still taken while a result waits
// at the output. Write the mode only while no pixel is in flight; the
// configuration channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_hsl_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rhc_cfg_if.sink          cfg,
    rhc_pixel_in_if.sink     pixel_in,
    rhc_pixel_out_if.source  pixel_out
);
    import rhc_pkg::*;

    // Mode register
    logic mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            mode_reg <= cfg.hsl_mode;
        end
    end

    // Handshake chain
    logic a_ready;
    logic b_ready;
    logic div_in_ready;
    logic div_out_valid;
    logic o_ready;

    // Stage A: max, min and sector
    logic       a_valid_reg;
    logic [7:0] a_red_reg;
    logic [7:0] a_green_reg;
    logic [7:0] a_blue_reg;
    logic [7:0] a_alpha_reg;
    logic [7:0] a_max_reg;
    logic [7:0] a_min_reg;
    logic       a_red_max_reg;
    logic       a_green_max_reg;
    logic [7:0] a_max_next;
    logic [7:0] a_min_next;
    logic       a_red_max_next;
    logic       a_green_max_next;

    assign a_ready = !a_valid_reg || b_ready;

    always_comb
    begin
        a_max_next = pixel_in.red;
        a_min_next = pixel_in.red;
        if (pixel_in.green > a_max_next)
        begin
            a_max_next = pixel_in.green;
        end
        if (pixel_in.blue > a_max_next)
        begin
            a_max_next = pixel_in.blue;
        end
        if (pixel_in.green < a_min_next)
        begin
            a_min_next = pixel_in.green;
        end
        if (pixel_in.blue < a_min_next)
        begin
            a_min_next = pixel_in.blue;
        end
        // ties go to red, then green
        a_red_max_next   = (pixel_in.red == a_max_next);
        a_green_max_next = !a_red_max_next && (pixel_in.green == a_max_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= pixel_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && pixel_in.valid)
        begin
            a_red_reg       <= pixel_in.red;
            a_green_reg     <= pixel_in.green;
            a_blue_reg      <= pixel_in.blue;
            a_alpha_reg     <= pixel_in.alpha_in;
            a_max_reg       <= a_max_next;
            a_min_reg       <= a_min_next;
            a_red_max_reg   <= a_red_max_next;
            a_green_max_reg <= a_green_max_next;
        end
    end

    assign pixel_in.ready = a_ready;

    // Stage B: dividends, divisors and level
    logic        b_valid_reg;
    rhc_div_t    b_word_reg;
    rhc_div_t    b_word_next;
    logic [7:0]  chroma;
    logic [10:0] chroma2;
    logic [10:0] chroma4;
    logic [10:0] chroma6;
    logic [10:0] hue_num;
    logic [8:0]  sum;
    logic [8:0]  upper_den;
    logic [7:0]  sat_den;

    assign b_ready = !b_valid_reg || div_in_ready;

    always_comb
    begin
        chroma  = a_max_reg - a_min_reg;
        chroma2 = {2'b00, chroma, 1'b0};
        chroma4 = {1'b0, chroma, 2'b00};
        chroma6 = chroma4 + chroma2;

        if (a_red_max_reg)
        begin
            if (a_green_reg >= a_blue_reg)
            begin
                hue_num = {3'b000, a_green_reg} - {3'b000, a_blue_reg};
            end
            else
            begin
                hue_num = chroma6 - ({3'b000, a_blue_reg} - {3'b000, a_green_reg});
            end
        end
        else if (a_green_max_reg)
        begin
            hue_num = {3'b000, a_blue_reg} + chroma2 - {3'b000, a_red_reg};
        end
        else
        begin
            hue_num = {3'b000, a_red_reg} + chroma4 - {3'b000, a_green_reg};
        end

        sum       = {1'b0, a_max_reg} + {1'b0, a_min_reg};
        upper_den = RHC_FULL_SUM - sum;
        if (mode_reg)
        begin
            sat_den = (sum < RHC_HALF_SUM) ? sum[7:0] : upper_den[7:0];
        end
        else
        begin
            sat_den = a_max_reg;
        end

        b_word_next.hue_rem  = hue_num;
        b_word_next.hue_den  = chroma6;
        b_word_next.hue_q    = '0;
        b_word_next.hue_zero = (chroma == 8'd0);
        b_word_next.sat_zero = (sat_den == 8'd0);
        b_word_next.sat_full = (sat_den != 8'd0) && (chroma == sat_den);
        // a ratio of one is forced at the output; keep the dividend below
        // the divisor so the quotient fits
        b_word_next.sat_rem  = b_word_next.sat_full ? 8'd0 : chroma;
        b_word_next.sat_den  = sat_den;
        b_word_next.sat_q    = '0;
        b_word_next.level    = mode_reg ? sum : {a_max_reg, 1'b0};
        b_word_next.alpha    = a_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_word_reg <= b_word_next;
        end
    end

    // Divider stages
    rhc_div_t div_out_word;

    rhc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (div_in_ready),
        .in_word   (b_word_reg),
        .out_valid (div_out_valid),
        .out_ready (o_ready),
        .out_word  (div_out_word)
    );

    // Output register
    logic        o_valid_reg;
    logic [15:0] o_hue_reg;
    logic [15:0] o_sat_reg;
    logic [8:0]  o_level_reg;
    logic [7:0]  o_alpha_reg;
    logic [15:0] o_hue_next;
    logic [15:0] o_sat_next;

    assign o_ready = !o_valid_reg || pixel_out.ready;

    always_comb
    begin
        o_hue_next = div_out_word.hue_zero ? 16'd0 : div_out_word.hue_q;
        if (div_out_word.sat_zero)
        begin
            o_sat_next = 16'd0;
        end
        else if (div_out_word.sat_full)
        begin
            o_sat_next = RHC_SAT_MAX;
        end
        else
        begin
            o_sat_next = div_out_word.sat_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && div_out_valid)
        begin
            o_hue_reg   <= o_hue_next;
            o_sat_reg   <= o_sat_next;
            o_level_reg <= div_out_word.level;
            o_alpha_reg <= div_out_word.alpha;
        end
    end

    assign pixel_out.valid      = o_valid_reg;
    assign pixel_out.hue        = o_hue_reg;
    assign pixel_out.saturation = o_sat_reg;
    assign pixel_out.level      = o_level_reg;
    assign pixel_out.alpha_out  = o_alpha_reg;

endmodule

`default_nettype wire

>>> src/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks on the converter, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hsv_hsl_converter_macros.svh"

module rhc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] hue,
    input wire logic [15:0] saturation,
    input wire logic [8:0]  level,
    input wire logic [7:0]  alpha_out
);

    // A stalled result word holds.
    `RHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hue) && $stable(saturation) && $stable(level) && $stable(alpha_out))

    // Input backpressure only comes from a stalled output.
    `RHC_ASSERT_SAME(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

    // Nonzero chroma always gives nonzero saturation.
    `RHC_ASSERT_SAME(a_sat_hue, clk, rst_n, out_valid && (saturation == 16'd0), hue == 16'd0)

    // Level stays within full scale on a valid result word while input is also offered.
    `RHC_ASSERT_SAME(a_level_range, clk, rst_n, out_valid && in_valid, level <= 9'd510)

endmodule

bind rgb_to_hsv_hsl_converter rhc_checker u_rhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel_in.valid),
    .in_ready   (pixel_in.ready),
    .out_valid  (pixel_out.valid),
    .out_ready  (pixel_out.ready),
    .hue        (pixel_out.hue),
    .saturation (pixel_out.saturation),
    .level      (pixel_out.level),
    .alpha_out  (pixel_out.alpha_out)
);

`default_nettype wire

>>> tb/sv/rgb_to_hsv_hsl_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_converter_tb
// Self-checking bench for the RGBA to HSV / HSL converter. A table of
// directed pixels covers primaries, ties, gray and the zero-divisor and
// full-scale cases in both modes. Random pixels follow in four phases, and
// the mode is rewritten between phases. Each output word is checked against
// typed values or an integer model while both channels idle and stall.
// ----------------------------------------------------------------------------

module rgb_to_hsv_hsl_converter_tb;

    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HSL = 1'b1;

    localparam int PIPE_LATENCY  = 11;
    localparam int DIR_ROWS      = 25;
    localparam int RAND_PHASES   = 4;
    localparam int RAND_PER_PHASE = 175;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [8:0]  level;
        logic [7:0]  alpha;
    } hsx_word_t;

    typedef struct packed {
        logic        mode;
        pixel_t      pix;
        logic        known;
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [8:0]  level;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rhc_cfg_if       cfg_ch ();
    rhc_pixel_in_if  pixel_in_ch ();
    rhc_pixel_out_if pixel_out_ch ();

    rgb_to_hsv_hsl_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .pixel_in  (pixel_in_ch),
        .pixel_out (pixel_out_ch)
    );

    hsx_word_t hsx_expected [$];
    logic      mode_now;
    int        fail_count;
    int        burst_left;

    // Expected values are typed in only where they follow at a glance.
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{MODE_HSV, '{8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, 16'd0,     16'd0,     9'd0},
        '{MODE_HSV, '{8'd255, 8'd255, 8'd255, 8'hFF}, 1'b1, 16'd0,     16'd0,     9'd510},
        '{MODE_HSV, '{8'd255, 8'd0,   8'd0,   8'h55}, 1'b1, 16'd0,     16'd65535, 9'd510},
        '{MODE_HSV, '{8'd0,   8'd255, 8'd0,   8'hAA}, 1'b1, 16'd21845, 16'd65535, 9'd510},
        '{MODE_HSV, '{8'd0,   8'd0,   8'd255, 8'h0F}, 1'b1, 16'd43690, 16'd65535, 9'd510},
        '{MODE_HSV, '{8'd255, 8'd255, 8'd0,   8'hF0}, 1'b1, 16'd10922, 16'd65535, 9'd510},
        '{MODE_HSV, '{8'd0,   8'd255, 8'd255, 8'h01}, 1'b1, 16'd32768, 16'd65535, 9'd510},
        '{MODE_HSV, '{8'd255, 8'd0,   8'd255, 8'h80}, 1'b1, 16'd54613, 16'd65535, 9'd510},
        '{MODE_HSV, '{8'd255, 8'd0,   8'd1,   8'h7F}, 1'b0, 16'd0,     16'd0,     9'd0},
        '{MODE_HSV, '{8'd128, 8'd128, 8'd128, 8'h33}, 1'b1, 16'd0,     16'd0,     9'd256},
        '{MODE_HSV, '{8'd1,   8'd0,   8'd0,   8'hFE}, 1'b1, 16'd0,     16'd65535, 9'd2},
        '{MODE_HSV, '{8'd0,   8'd1,   8'd1,   8'hC0}, 1'b1, 16'd32768, 16'd65535, 9'd2},
        '{MODE_HSV, '{8'd200, 8'd100, 8'd50,  8'h5A}, 1'b0, 16'd0,     16'd0,     9'd0},
        '{MODE_HSV, '{8'd10,  8'd250, 8'd130, 8'hA5}, 1'b0, 16'd0,     16'd0,     9'd0},
        '{MODE_HSL, '{8'd0,   8'd0,   8'd0,   8'hFF}, 1'b1, 16'd0,     16'd0,     9'd0},
        '{MODE_HSL, '{8'd255, 8'd255, 8'd255, 8'h00}, 1'b1, 16'd0,     16'd0,     9'd510},
        '{MODE_HSL, '{8'd255, 8'd0,   8'd0,   8'h55}, 1'b1, 16'd0,     16'd65535, 9'd255},
        '{MODE_HSL, '{8'd254, 8'd0,   8'd0,   8'hAA}, 1'b1, 16'd0,     16'd65535, 9'd254},
        '{MODE_HSL, '{8'd255, 8'd1,   8'd1,   8'h3C}, 1'b1, 16'd0,     16'd65535, 9'd256},
        '{MODE_HSL, '{8'd1,   8'd0,   8'd0,   8'hC3}, 1'b1, 16'd0,     16'd65535, 9'd1},
        '{MODE_HSL, '{8'd100, 8'd100, 8'd100, 8'h11}, 1'b1, 16'd0,     16'd0,     9'd200},
        '{MODE_HSL, '{8'd200, 8'd100, 8'd50,  8'h5A}, 1'b0, 16'd0,     16'd0,     9'd0},
        '{MODE_HSL, '{8'd0,   8'd128, 8'd255, 8'hE7}, 1'b0, 16'd0,     16'd0,     9'd0},
        '{MODE_HSL, '{8'd128, 8'd64,  8'd64,  8'h99}, 1'b0, 16'd0,     16'd0,     9'd0},
        '{MODE_HSL, '{8'd255, 8'd200, 8'd128, 8'h66}, 1'b0, 16'd0,     16'd0,     9'd0}
    };

    function automatic int unsigned sat_fraction(input int unsigned num,
                                                 input int unsigned den);
        int unsigned q;
        if (den == 0)
        begin
            return 0;
        end
        q = (num << 16) / den;
        return (q > rhc_pkg::RHC_SAT_MAX) ? rhc_pkg::RHC_SAT_MAX : q;
    endfunction

    function automatic hsx_word_t predict_hsx(input pixel_t p, input logic hsl);
        hsx_word_t   w;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned c;
        int unsigned h;
        int unsigned q;
        int unsigned sum;
        r  = p.red;
        g  = p.green;
        b  = p.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;

        // ties resolve red first, then green
        if (c == 0)
        begin
            q = 0;
        end
        else
        begin
            if (r == mx)
            begin
                h = (g >= b) ? g - b : 6 * c - (b - g);
            end
            else if (g == mx)
            begin
                h = b + 2 * c - r;
            end
            else
            begin
                h = r + 4 * c - g;
            end
            q = (h << 16) / (6 * c);
            if (q > 65535) q = 65535;
        end
        w.hue = q[15:0];

        sum = mx + mn;
        if (hsl == MODE_HSL)
        begin
            w.level = sum[8:0];
            if (sum < rhc_pkg::RHC_HALF_SUM)
            begin
                q = sat_fraction(c, sum);
            end
            else
            begin
                q = sat_fraction(c, rhc_pkg::RHC_FULL_SUM - sum);
            end
        end
        else
        begin
            w.level = 9'(2 * mx);
            q = sat_fraction(c, mx);
        end
        w.saturation = q[15:0];
        w.alpha = p.alpha;
        return w;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int     kind;
        p.red   = 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
        p.alpha = 8'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                p.green = p.red;
                p.blue  = p.red;
            end
            1: p.green = p.red;
            2: p.blue = p.green;
            3: p.blue = p.red;
            4:
            begin
                p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            5:
            begin
                // straddle the lightness half
                p.red   = 8'($urandom_range(120, 135));
                p.green = 8'($urandom_range(120, 135));
                p.blue  = 8'($urandom_range(120, 135));
            end
            6:
            begin
                p.red   = 8'($urandom_range(0, 3));
                p.green = 8'($urandom_range(0, 3));
                p.blue  = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p, input hsx_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pixel_in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        pixel_in_ch.valid    <= 1'b1;
        pixel_in_ch.red      <= p.red;
        pixel_in_ch.green    <= p.green;
        pixel_in_ch.blue     <= p.blue;
        pixel_in_ch.alpha_in <= p.alpha;
        @(posedge clk);
        while (!pixel_in_ch.ready) @(posedge clk);
        hsx_expected.push_back(w);
        burst_left--;
    endtask

    // Hold input until every result is out, then let the pipe settle.
    task automatic drain_pipeline();
        pixel_in_ch.valid <= 1'b0;
        burst_left = 0;
        while (hsx_expected.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_hsl_mode(input logic m);
        drain_pipeline();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.hsl_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        mode_now = m;
    endtask

    // Output side: check each accepted word, then pick next cycle's ready.
    hsx_word_t exp_word;
    int        stall_cycle;
    int        stall_style;
    int        stall_hold;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_out_ch.valid && pixel_out_ch.ready)
            begin
                if (hsx_expected.size() == 0)
                begin
                    $error("unexpected word: hue %0d saturation %0d level %0d alpha %0d",
                           pixel_out_ch.hue, pixel_out_ch.saturation,
                           pixel_out_ch.level, pixel_out_ch.alpha_out);
                    fail_count++;
                end
                else
                begin
                    exp_word = hsx_expected.pop_front();
                    if (pixel_out_ch.hue !== exp_word.hue)
                    begin
                        $error("hue: expected %0d, actual %0d",
                               exp_word.hue, pixel_out_ch.hue);
                        fail_count++;
                    end
                    if (pixel_out_ch.saturation !== exp_word.saturation)
                    begin
                        $error("saturation: expected %0d, actual %0d",
                               exp_word.saturation, pixel_out_ch.saturation);
                        fail_count++;
                    end
                    if (pixel_out_ch.level !== exp_word.level)
                    begin
                        $error("level: expected %0d, actual %0d",
                               exp_word.level, pixel_out_ch.level);
                        fail_count++;
                    end
                    if (pixel_out_ch.alpha_out !== exp_word.alpha)
                    begin
                        $error("alpha_out: expected %0d, actual %0d",
                               exp_word.alpha, pixel_out_ch.alpha_out);
                        fail_count++;
                    end
                end
            end

            stall_cycle++;
            if (stall_cycle % 64 == 0)
            begin
                stall_style = $urandom_range(0, 3);
            end
            case (stall_style)
                0: pixel_out_ch.ready <= 1'b1;
                1: pixel_out_ch.ready <= (stall_cycle % 3 != 0);
                2: pixel_out_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_hold > 0)
                    begin
                        stall_hold--;
                        pixel_out_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        pixel_out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                        begin
                            stall_hold = $urandom_range(1, 15);
                        end
                    end
                end
            endcase
        end
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        hsx_word_t w;
        pixel_t    p;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.hsl_mode      = MODE_HSV;
        pixel_in_ch.valid    = 1'b0;
        pixel_in_ch.red      = 8'd0;
        pixel_in_ch.green    = 8'd0;
        pixel_in_ch.blue     = 8'd0;
        pixel_in_ch.alpha_in = 8'd0;
        pixel_out_ch.ready   = 1'b0;
        mode_now             = MODE_HSV;
        fail_count           = 0;
        burst_left           = 0;
        stall_cycle          = 0;
        stall_style          = 0;
        stall_hold           = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first rows run on the reset mode
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].mode != mode_now)
            begin
                write_hsl_mode(dir_rows[i].mode);
            end
            if (dir_rows[i].known)
            begin
                w.hue        = dir_rows[i].hue;
                w.saturation = dir_rows[i].saturation;
                w.level      = dir_rows[i].level;
                w.alpha      = dir_rows[i].pix.alpha;
            end
            else
            begin
                w = predict_hsx(dir_rows[i].pix, mode_now);
            end
            send_pixel(dir_rows[i].pix, w);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_hsl_mode((ph % 2 == 0) ? MODE_HSV : MODE_HSL);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                p = random_pixel();
                send_pixel(p, predict_hsx(p, mode_now));
            end
        end

        pixel_in_ch.valid <= 1'b0;
        while (hsx_expected.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
